/* rtl/core/prls_pkg.sv */
// Shared types and constants of the priority ready-list scheduler.
package prls_pkg;

	localparam int MAX_TASKS_DEF     = 16;
	localparam int PRIORITY_BITS_DEF = 8;
	localparam int ID_W              = 4;
	localparam int PRIO_IN_W         = 8;
	localparam int OUTCOME_W         = 3;

	// Input beat kinds
	localparam logic MODE_ADD   = 1'b0;
	localparam logic MODE_SCHED = 1'b1;

	typedef enum logic [OUTCOME_W-1:0] {
		OUT_ADDED    = 3'd0,
		OUT_FULL     = 3'd1,
		OUT_SWITCHED = 3'd2,
		OUT_KEPT     = 3'd3,
		OUT_EMPTY    = 3'd4
	} outcome_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic     add_wr;    // append the incoming task at the list tail
		logic     scan_rd;   // the current read feeds the best-priority search
		logic     remove;    // move the last entry into the chosen slot
		logic     out_load;  // load the result register
		outcome_t out_code;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic empty;
		logic full;
		logic has_running;
	} stat_t;

endpackage

/* rtl/core/prls_ctrl.sv */
// Controller state machine of the priority ready-list scheduler.
module prls_ctrl #(
	parameter  int MAX_TASKS = prls_pkg::MAX_TASKS_DEF,
	localparam int IW        = $clog2(MAX_TASKS),
	localparam int CW        = $clog2(MAX_TASKS + 1)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  mode,
	input  logic                  running_finished,
	output logic                  out_valid,
	input  logic                  out_ready,
	input  prls_pkg::stat_t       stat,
	input  logic [CW-1:0]         count,
	output prls_pkg::cmd_t        cmd,
	output logic [IW-1:0]         rd_addr
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_MOVE,
		ST_WRITE
	} state_t;

	state_t        state_q;
	state_t        state_d;
	logic [IW-1:0] scan_idx_q;
	logic          out_valid_q;
	logic [IW-1:0] last_idx;
	logic          accept;

	assign last_idx  = IW'(count - CW'(1));
	assign in_ready  = (state_q == ST_IDLE) && (!out_valid_q || out_ready);
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;

	// Decode the current state into datapath commands
	always_comb begin
		cmd          = '0;
		cmd.out_code = prls_pkg::OUT_ADDED;
		rd_addr      = scan_idx_q;
		state_d      = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (mode == prls_pkg::MODE_ADD) begin
						cmd.out_load = 1'b1;
						if (stat.full) begin
							cmd.out_code = prls_pkg::OUT_FULL;
						end else begin
							cmd.add_wr   = 1'b1;
							cmd.out_code = prls_pkg::OUT_ADDED;
						end
					end else if (stat.empty) begin
						cmd.out_load = 1'b1;
						cmd.out_code = prls_pkg::OUT_EMPTY;
					end else if (stat.has_running && !running_finished) begin
						cmd.out_load = 1'b1;
						cmd.out_code = prls_pkg::OUT_KEPT;
					end else begin
						state_d = ST_SCAN;
					end
				end
			end
			ST_SCAN: begin
				cmd.scan_rd = 1'b1;
				if (scan_idx_q == last_idx) begin
					state_d = ST_MOVE;
				end
			end
			ST_MOVE: begin
				// fetch the tail entry while the last compare completes
				rd_addr = last_idx;
				state_d = ST_WRITE;
			end
			ST_WRITE: begin
				cmd.remove   = 1'b1;
				cmd.out_load = 1'b1;
				cmd.out_code = prls_pkg::OUT_SWITCHED;
				state_d      = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Hold state, scan index and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			scan_idx_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_SCAN) begin
				scan_idx_q <= scan_idx_q + IW'(1);
			end else begin
				scan_idx_q <= '0;
			end
			out_valid_q <= cmd.out_load || (out_valid_q && !out_ready);
		end
	end

`ifndef NO_ASSERTIONS
	// A new result never overwrites one that is still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || out_ready))
		else $error("result register overwritten");

	// The scan never runs past the end of the list
	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> ((CW+1)'(scan_idx_q) < (CW+1)'(count)))
		else $error("scan beyond list end");
`endif

endmodule

/* rtl/core/prls_dp.sv */
// Datapath of the priority ready-list scheduler: ready list memory, search and result register.
module prls_dp #(
	parameter  int MAX_TASKS     = prls_pkg::MAX_TASKS_DEF,
	parameter  int PRIORITY_BITS = prls_pkg::PRIORITY_BITS_DEF,
	localparam int IW            = $clog2(MAX_TASKS),
	localparam int CW            = $clog2(MAX_TASKS + 1)
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic [prls_pkg::ID_W-1:0]         task_id,
	input  logic [prls_pkg::PRIO_IN_W-1:0]    task_priority,
	input  prls_pkg::cmd_t                    cmd,
	input  logic [IW-1:0]                     rd_addr,
	output prls_pkg::stat_t                   stat,
	output logic [CW-1:0]                     count,
	output logic [prls_pkg::OUTCOME_W-1:0]    outcome,
	output logic [prls_pkg::ID_W-1:0]         chosen_id,
	output logic [prls_pkg::PRIO_IN_W-1:0]    chosen_priority
);

	localparam int PW = PRIORITY_BITS;

	logic [prls_pkg::ID_W-1:0]              id_mem [MAX_TASKS];
	logic [PW-1:0]                          prio_mem [MAX_TASKS];

	logic [CW-1:0]                          count_q;
	logic                                   has_running_q;
	logic                                   scan_vld_s1;
	logic [prls_pkg::ID_W-1:0]              rd_id_s1;
	logic [PW-1:0]                          rd_prio_s1;
	logic [IW-1:0]                          rd_idx_s1;
	logic [prls_pkg::ID_W-1:0]              best_id_q;
	logic [PW-1:0]                          best_prio_q;
	logic [IW-1:0]                          best_idx_q;
	logic [prls_pkg::OUTCOME_W-1:0]         outcome_q;
	logic [prls_pkg::ID_W-1:0]              chosen_id_q;
	logic [prls_pkg::PRIO_IN_W-1:0]         chosen_prio_q;

	logic [PW+prls_pkg::PRIO_IN_W-1:0]      prio_in_wide;
	logic [PW+prls_pkg::PRIO_IN_W-1:0]      prio_out_wide;
	logic [PW-1:0]                          prio_in;
	logic                                   mem_we;
	logic [IW-1:0]                          mem_waddr;
	logic [prls_pkg::ID_W-1:0]              mem_wid;
	logic [PW-1:0]                          mem_wprio;

	// Fit the incoming priority to the stored width, and the stored one to the port
	assign prio_in_wide  = {{PW{1'b0}}, task_priority};
	assign prio_in       = prio_in_wide[PW-1:0];
	assign prio_out_wide = {{prls_pkg::PRIO_IN_W{1'b0}}, best_prio_q};

	// Write port: append at the tail, or move the tail into the chosen slot
	assign mem_we    = cmd.add_wr || cmd.remove;
	assign mem_waddr = cmd.add_wr ? IW'(count_q) : best_idx_q;
	assign mem_wid   = cmd.add_wr ? task_id : rd_id_s1;
	assign mem_wprio = cmd.add_wr ? prio_in : rd_prio_s1;

	// Ready list memory with registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			id_mem[mem_waddr]   <= mem_wid;
			prio_mem[mem_waddr] <= mem_wprio;
		end
		rd_id_s1   <= id_mem[rd_addr];
		rd_prio_s1 <= prio_mem[rd_addr];
		rd_idx_s1  <= rd_addr;
	end

	// Track the first entry of strictly highest priority
	always_ff @(posedge clk) begin
		if (scan_vld_s1 && (rd_idx_s1 == '0 || rd_prio_s1 > best_prio_q)) begin
			best_id_q   <= rd_id_s1;
			best_prio_q <= rd_prio_s1;
			best_idx_q  <= rd_idx_s1;
		end
	end

	// List fill, running flag and scan read valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q       <= '0;
			has_running_q <= 1'b0;
			scan_vld_s1   <= 1'b0;
		end else begin
			scan_vld_s1 <= cmd.scan_rd;
			if (cmd.add_wr) begin
				count_q <= count_q + CW'(1);
			end else if (cmd.remove) begin
				count_q       <= count_q - CW'(1);
				has_running_q <= 1'b1;
			end
		end
	end

	// Load the result beat
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			outcome_q <= cmd.out_code;
			if (cmd.out_code == prls_pkg::OUT_SWITCHED) begin
				chosen_id_q   <= best_id_q;
				chosen_prio_q <= prio_out_wide[prls_pkg::PRIO_IN_W-1:0];
			end else begin
				chosen_id_q   <= '0;
				chosen_prio_q <= '0;
			end
		end
	end

	assign stat.empty       = (count_q == '0);
	assign stat.full        = (count_q == CW'(MAX_TASKS));
	assign stat.has_running = has_running_q;
	assign count            = count_q;
	assign outcome          = outcome_q;
	assign chosen_id        = chosen_id_q;
	assign chosen_priority  = chosen_prio_q;

`ifndef NO_ASSERTIONS
	// The fill count never goes past the list depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q <= CW'(MAX_TASKS)))
		else $error("ready count beyond depth");

	// Removal only happens on a non-empty list and never with an append
	a_remove_ok: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.remove |-> (count_q != '0 && !cmd.add_wr))
		else $error("removal from empty list");
`endif

endmodule

/* rtl/core/priority_ready_list_scheduler_core.sv */
// Top level of the priority ready-list scheduler: controller plus datapath.
// An add beat (mode 0) appends a task to the ready list, or reports the list full; a
// schedule beat (mode 1) reports an empty list or a running task kept in one step, and
// otherwise searches the list for the first entry of highest priority, fills its slot with
// the tail entry and reports the switch. Adds, drops, empty and kept results appear in the
// cycle after the beat is taken. For a switch, the search reads one list entry per cycle
// through the single read port of the ready list memory, then a move state fetches the
// tail entry and a write state writes it back. One item is worked on at a time; the next
// beat is taken once the block is idle and the result register is empty or being emptied.
module priority_ready_list_scheduler_core #(
	parameter int MAX_TASKS     = prls_pkg::MAX_TASKS_DEF,
	parameter int PRIORITY_BITS = prls_pkg::PRIORITY_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              mode,
	input  logic [prls_pkg::ID_W-1:0]         task_id,
	input  logic [prls_pkg::PRIO_IN_W-1:0]    task_priority,
	input  logic                              running_finished,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [prls_pkg::OUTCOME_W-1:0]    outcome,
	output logic [prls_pkg::ID_W-1:0]         chosen_id,
	output logic [prls_pkg::PRIO_IN_W-1:0]    chosen_priority
);

	localparam int IW = $clog2(MAX_TASKS);
	localparam int CW = $clog2(MAX_TASKS + 1);

	prls_pkg::cmd_t  cmd;
	prls_pkg::stat_t stat;
	logic [IW-1:0]   rd_addr;
	logic [CW-1:0]   count;

	prls_ctrl #(
		.MAX_TASKS (MAX_TASKS)
	) u_ctrl (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.mode             (mode),
		.running_finished (running_finished),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.stat             (stat),
		.count            (count),
		.cmd              (cmd),
		.rd_addr          (rd_addr)
	);

	prls_dp #(
		.MAX_TASKS     (MAX_TASKS),
		.PRIORITY_BITS (PRIORITY_BITS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.task_id         (task_id),
		.task_priority   (task_priority),
		.cmd             (cmd),
		.rd_addr         (rd_addr),
		.stat            (stat),
		.count           (count),
		.outcome         (outcome),
		.chosen_id       (chosen_id),
		.chosen_priority (chosen_priority)
	);

endmodule

/* tb/sv/priority_ready_list_scheduler_core_tb.sv */
// Self-checking testbench of the priority ready-list scheduler core.
`timescale 1ns / 100ps

module priority_ready_list_scheduler_core_tb;

	localparam int NUM_SLOTS     = prls_pkg::MAX_TASKS_DEF;
	localparam int ID_W          = prls_pkg::ID_W;
	localparam int PRIO_IN_W     = prls_pkg::PRIO_IN_W;
	localparam int OUTCOME_W     = prls_pkg::OUTCOME_W;
	localparam int TOTAL_BEATS   = 1100;
	localparam int CALM_FROM     = 1000;
	localparam int STALL_LIMIT   = 2000;
	localparam int SETTLE_CYCLES = NUM_SLOTS + 12;
	localparam int REPORT_MAX    = 10;

	typedef struct packed {
		prls_pkg::outcome_t     code;
		logic [ID_W-1:0]        id;
		logic [PRIO_IN_W-1:0]   prio;
	} sched_result_t;

	// Mirror of the ready list plus the queue of schedule results still owed.
	class sched_scoreboard;
		bit [ID_W-1:0]      list_ids[NUM_SLOTS];
		bit [PRIO_IN_W-1:0] list_prios[NUM_SLOTS];
		int unsigned        list_count;
		bit                 task_running;
		sched_result_t      owed_results[$];
		int unsigned        mismatches;

		function new();
			list_count   = 0;
			task_running = 1'b0;
			mismatches   = 0;
		endfunction

		function int unsigned pending();
			return owed_results.size();
		endfunction

		// Apply one accepted input beat to the mirror and queue its result.
		function void note_beat(bit m, bit [ID_W-1:0] id, bit [PRIO_IN_W-1:0] pr, bit fin);
			sched_result_t r;
			int unsigned   best;
			int unsigned   tail;
			r = '{code: prls_pkg::OUT_ADDED, id: '0, prio: '0};
			if (m == prls_pkg::MODE_ADD) begin
				if (list_count >= NUM_SLOTS) begin
					r.code = prls_pkg::OUT_FULL;
				end else begin
					list_ids[list_count]   = id;
					list_prios[list_count] = pr;
					list_count++;
				end
			end else if (list_count == 0) begin
				r.code = prls_pkg::OUT_EMPTY;
			end else if (task_running && !fin) begin
				r.code = prls_pkg::OUT_KEPT;
			end else begin
				// first entry of strictly highest priority wins
				best = 0;
				for (int unsigned i = 1; i < list_count; i++) begin
					if (list_prios[i] > list_prios[best])
						best = i;
				end
				r.code = prls_pkg::OUT_SWITCHED;
				r.id   = list_ids[best];
				r.prio = list_prios[best];
				tail = list_count - 1;
				list_ids[best]   = list_ids[tail];
				list_prios[best] = list_prios[tail];
				list_count   = tail;
				task_running = 1'b1;
			end
			owed_results.push_back(r);
		endfunction

		// Compare one accepted result beat with the oldest owed result.
		function void check_result(logic [OUTCOME_W-1:0] oc, logic [ID_W-1:0] id,
				logic [PRIO_IN_W-1:0] pr);
			sched_result_t want;
			if (owed_results.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_MAX)
					$display("%0t: unexpected result beat: outcome %0d id %0d prio %0d",
						$realtime, oc, id, pr);
				return;
			end
			want = owed_results.pop_front();
			if (oc !== want.code || id !== want.id || pr !== want.prio) begin
				mismatches++;
				if (mismatches <= REPORT_MAX) begin
					$write("%0t: result mismatch: expected outcome %0d id %0d prio %0d, ",
						$realtime, want.code, want.id, want.prio);
					$display("got outcome %0d id %0d prio %0d", oc, id, pr);
				end
			end
		endfunction
	endclass

	logic                   clk;
	logic                   arst_n           = 1'b0;
	logic                   in_valid         = 1'b0;
	logic                   in_ready;
	logic                   mode             = 1'b0;
	logic [ID_W-1:0]        task_id          = '0;
	logic [PRIO_IN_W-1:0]   task_priority    = '0;
	logic                   running_finished = 1'b0;
	logic                   out_valid;
	logic                   out_ready        = 1'b0;
	logic [OUTCOME_W-1:0]   outcome;
	logic [ID_W-1:0]        chosen_id;
	logic [PRIO_IN_W-1:0]   chosen_priority;

	sched_scoreboard sb = new();
	bit              send_idle_en = 1'b1;
	bit              recv_stall_en = 1'b1;
	int unsigned     beats_sent = 0;

	priority_ready_list_scheduler_core u_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.mode             (mode),
		.task_id          (task_id),
		.task_priority    (task_priority),
		.running_finished (running_finished),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.outcome          (outcome),
		.chosen_id        (chosen_id),
		.chosen_priority  (chosen_priority)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Sample both channels at the edge and feed the scoreboard.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				sb.note_beat(mode, task_id, task_priority, running_finished);
			if (out_valid && out_ready)
				sb.check_result(outcome, chosen_id, chosen_priority);
		end
	end

	// Stall the result channel in random bursts.
	initial begin
		@(posedge clk iff arst_n);
		forever begin
			if (recv_stall_en && $urandom_range(0, 3) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 18)) @(posedge clk);
			end
			out_ready <= 1'b1;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	end

	// End the run when neither channel moves a beat for too long.
	initial begin
		int unsigned quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("Verification failed");
		$finish;
	end

	// Present one input beat, optionally after an idle burst, and hold it until taken.
	task automatic send_beat(input bit m, input bit [ID_W-1:0] id,
			input bit [PRIO_IN_W-1:0] pr, input bit fin);
		if (send_idle_en && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
		in_valid         <= 1'b1;
		mode             <= m;
		task_id          <= id;
		task_priority    <= pr;
		running_finished <= fin;
		do @(posedge clk); while (!in_ready);
		beats_sent++;
	endtask

	// Hold off the sender until every owed result has been taken.
	task automatic drain_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
	endtask

	initial begin
		int unsigned add_pct;
		int unsigned run_len;
		bit          tie_heavy;
		bit          m;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// schedule on an empty list, with and without a finished task
		send_beat(prls_pkg::MODE_SCHED, 4'hF, 8'hFF, 1'b0);
		send_beat(prls_pkg::MODE_SCHED, 4'h0, 8'h00, 1'b1);
		// extremes of id and priority, duplicate ids and a priority tie
		send_beat(prls_pkg::MODE_ADD, 4'h0, 8'h00, 1'b1);
		send_beat(prls_pkg::MODE_ADD, 4'hF, 8'hFF, 1'b0);
		send_beat(prls_pkg::MODE_ADD, 4'hF, 8'hFF, 1'b1);
		send_beat(prls_pkg::MODE_ADD, 4'h5, 8'h80, 1'b0);
		// nothing running: switch even though not finished
		send_beat(prls_pkg::MODE_SCHED, 4'hA, 8'h55, 1'b0);
		// running task not finished: keep it
		send_beat(prls_pkg::MODE_SCHED, 4'h3, 8'hAA, 1'b0);
		send_beat(prls_pkg::MODE_SCHED, 4'hC, 8'h3C, 1'b1);
		// fill the list, then overflow it
		for (int i = 0; i < NUM_SLOTS - 2; i++)
			send_beat(prls_pkg::MODE_ADD, 4'(i + 1), 8'(i * 17 + 3), i[0]);
		send_beat(prls_pkg::MODE_ADD, 4'h9, 8'hC3, 1'b1);
		send_beat(prls_pkg::MODE_SCHED, 4'h6, 8'h99, 1'b1);
		drain_results();

		// random bursts of mostly adds, mostly schedules or an even mix
		while (beats_sent < TOTAL_BEATS) begin
			case ($urandom_range(0, 2))
				0: add_pct = 15;
				1: add_pct = 50;
				default: add_pct = 85;
			endcase
			run_len   = $urandom_range(8, 40);
			tie_heavy = $urandom_range(0, 1);
			if (beats_sent >= CALM_FROM) begin
				send_idle_en  = 1'b0;
				recv_stall_en = 1'b0;
			end else begin
				send_idle_en  = $urandom_range(0, 2) != 0;
				recv_stall_en = $urandom_range(0, 2) != 0;
			end
			for (int k = 0; k < run_len && beats_sent < TOTAL_BEATS; k++) begin
				m = ($urandom_range(0, 99) >= add_pct) ? prls_pkg::MODE_SCHED
					: prls_pkg::MODE_ADD;
				send_beat(m, 4'($urandom),
					tie_heavy ? 8'($urandom_range(0, 3)) : 8'($urandom),
					$urandom_range(0, 2) != 0);
			end
			if (beats_sent < CALM_FROM && $urandom_range(0, 5) == 0)
				drain_results();
		end
		in_valid <= 1'b0;

		// wait out owed results, then watch for stray beats
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (sb.pending() == 0 && sb.mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
